FILE: rtl/lcsr_pkg.sv
// Shared constants and controller/datapath interface types for the load cell reader.
package lcsr_pkg;

  // Converter sample and result widths
  localparam int SAMPLE_BITS = 24;
  localparam int RAW_W       = 24;
  localparam int BCNT_W      = 5;
  localparam int DIV_W       = 20;
  localparam int LIMIT_W     = 24;
  localparam int CFG_W       = 24;
  localparam int FRAC_BITS   = 4;
  localparam int QUO_W       = RAW_W + FRAC_BITS;
  localparam int DCNT_W      = $clog2(QUO_W);

  // Stream widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 56;

  // Constants of the conversion
  localparam logic [RAW_W-1:0]   SIGN_FLIP     = 24'h800000;
  localparam logic [RAW_W-1:0]   WEIGHT_SAT    = 24'hFFFFFF;
  localparam logic [DIV_W-1:0]   DIVISOR_RST   = 20'd6880;
  localparam logic [LIMIT_W-1:0] LIMIT_RST     = 24'd5000;

  // Request codes on func
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_TARE  = 2'd1;
  localparam logic [1:0] FUNC_WEIGH = 2'd2;

  // Configuration register indexes
  localparam logic CFG_IDX_DIVISOR = 1'b0;
  localparam logic CFG_IDX_LIMIT   = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic step;     // apply one tick to the reader state
    logic div_run;  // one divider iteration
  } lcsr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_start;  // the tick being applied starts a division
    logic div_last;   // final divider iteration this cycle
  } lcsr_stat_t;

endpackage

FILE: rtl/lcsr_ctrl.sv
// Sequencing controller: stream handshakes and divider iteration control.
module lcsr_ctrl
  import lcsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  output lcsr_cmd_t  cmd,
  input  lcsr_stat_t stat
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_tready   = (state_r == S_IDLE);
  assign out_tvalid  = (state_r == S_OUT);
  assign cmd.step    = in_tvalid && (state_r == S_IDLE);
  assign cmd.div_run = (state_r == S_DIV);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = stat.div_start ? S_DIV : S_OUT;
        end
      end
      S_DIV: begin
        if (stat.div_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/lcsr_dp.sv
// Reader datapath: serial phase tracking, shift register, tare, and restoring divider.
module lcsr_dp
  import lcsr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         func,
  input  logic               data_pin,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  lcsr_cmd_t          cmd,
  output lcsr_stat_t         stat,
  output logic               serial_clock,
  output logic               busy_res,
  output logic               done_res,
  output logic [RAW_W-1:0]   raw_count,
  output logic [RAW_W-1:0]   weight,
  output logic               overload
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_WAIT   = 3'd1;
  localparam logic [2:0] PH_HIGH   = 3'd2;
  localparam logic [2:0] PH_LOW    = 3'd3;
  localparam logic [2:0] PH_PULSE  = 3'd4;
  localparam logic [2:0] PH_FINISH = 3'd5;

  localparam logic [BCNT_W-1:0] LAST_BIT  = BCNT_W'(SAMPLE_BITS - 1);
  localparam logic [DCNT_W-1:0] LAST_STEP = DCNT_W'(QUO_W - 1);

  // Configuration
  logic [DIV_W-1:0]   divisor_r;
  logic [LIMIT_W-1:0] limit_r;

  // Reader state
  logic [2:0]        phase_r, phase_nxt;
  logic [BCNT_W-1:0] bit_count_r, bit_count_nxt;
  logic [RAW_W-1:0]  shift_r, shift_nxt;
  logic              kind_r, kind_nxt;
  logic [RAW_W-1:0]  tare_r, tare_nxt;
  logic [RAW_W-1:0]  last_raw_r, last_raw_nxt;
  logic [RAW_W-1:0]  weight_r, weight_nxt;
  logic              ovl_r, ovl_nxt;

  // Per-transaction output flags
  logic sclk_r, sclk_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;

  // Divider
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;

  logic [RAW_W-1:0] raw_val;
  logic [RAW_W:0]   diff;
  logic             diff_pos;
  logic [DIV_W-1:0] div_eff;
  logic [DIV_W:0]   rem_shift;
  logic [DIV_W+1:0] trial;
  logic [QUO_W-1:0] quo_step;
  logic [DIV_W-1:0] rem_step;

  assign raw_val  = shift_r ^ SIGN_FLIP;
  assign diff     = {1'b0, raw_val} - {1'b0, tare_r};
  assign diff_pos = !diff[RAW_W] && (diff[RAW_W-1:0] != '0);
  assign div_eff  = (divisor_r == '0) ? DIV_W'(1) : divisor_r;

  // One restoring division step
  always_comb begin
    rem_shift = {rem_r, quo_r[QUO_W-1]};
    trial     = {1'b0, rem_shift} - {2'b00, div_eff};
    if (!trial[DIV_W+1]) begin
      rem_step = trial[DIV_W-1:0];
      quo_step = {quo_r[QUO_W-2:0], 1'b1};
    end else begin
      rem_step = rem_shift[DIV_W-1:0];
      quo_step = {quo_r[QUO_W-2:0], 1'b0};
    end
  end

  assign stat.div_start = cmd.step && (phase_r == PH_FINISH) && kind_r && diff_pos;
  assign stat.div_last  = cmd.div_run && (dcnt_r == LAST_STEP);

  // Tick handling and divider sequencing
  always_comb begin
    phase_nxt     = phase_r;
    bit_count_nxt = bit_count_r;
    shift_nxt     = shift_r;
    kind_nxt      = kind_r;
    tare_nxt      = tare_r;
    last_raw_nxt  = last_raw_r;
    weight_nxt    = weight_r;
    ovl_nxt       = ovl_r;
    sclk_nxt      = sclk_r;
    busy_nxt      = busy_r;
    done_nxt      = done_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;

    if (cmd.step) begin
      sclk_nxt = 1'b0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      case (phase_r)
        PH_WAIT: begin
          if (!data_pin) begin
            bit_count_nxt = '0;
            shift_nxt     = '0;
            phase_nxt     = PH_HIGH;
          end
        end
        PH_HIGH: begin
          sclk_nxt  = 1'b1;
          shift_nxt = {shift_r[RAW_W-2:0], 1'b0};
          phase_nxt = PH_LOW;
        end
        PH_LOW: begin
          shift_nxt = {shift_r[RAW_W-1:1], shift_r[0] | data_pin};
          if (bit_count_r == LAST_BIT) begin
            phase_nxt = PH_PULSE;
          end else begin
            bit_count_nxt = bit_count_r + 1'b1;
            phase_nxt     = PH_HIGH;
          end
        end
        PH_PULSE: begin
          sclk_nxt  = 1'b1;
          phase_nxt = PH_FINISH;
        end
        PH_FINISH: begin
          last_raw_nxt = raw_val;
          done_nxt     = 1'b1;
          phase_nxt    = PH_IDLE;
          if (!kind_r) begin
            tare_nxt = raw_val;
          end else if (!diff_pos) begin
            weight_nxt = '0;
          end else begin
            // dividend is the difference scaled by the divisor's fraction bits
            quo_nxt  = {diff[RAW_W-1:0], {FRAC_BITS{1'b0}}};
            rem_nxt  = '0;
            dcnt_nxt = '0;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          if (func == FUNC_TARE || func == FUNC_WEIGH) begin
            kind_nxt  = (func == FUNC_WEIGH);
            phase_nxt = PH_WAIT;
          end else begin
            busy_nxt = 1'b0;
          end
        end
      endcase
    end

    if (cmd.div_run) begin
      quo_nxt  = quo_step;
      rem_nxt  = rem_step;
      dcnt_nxt = dcnt_r + 1'b1;
      // commit on the last step with saturation and full-width limit compare
      if (dcnt_r == LAST_STEP) begin
        weight_nxt = (quo_step[QUO_W-1:RAW_W] != '0) ? WEIGHT_SAT : quo_step[RAW_W-1:0];
        ovl_nxt    = (quo_step > {{(QUO_W-LIMIT_W){1'b0}}, limit_r});
      end
    end
  end

  // Control and reader state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisor_r   <= DIVISOR_RST;
      limit_r     <= LIMIT_RST;
      phase_r     <= PH_IDLE;
      bit_count_r <= '0;
      shift_r     <= '0;
      kind_r      <= 1'b0;
      tare_r      <= '0;
      last_raw_r  <= '0;
      weight_r    <= '0;
      ovl_r       <= 1'b0;
      sclk_r      <= 1'b0;
      busy_r      <= 1'b0;
      done_r      <= 1'b0;
      dcnt_r      <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_IDX_DIVISOR) begin
        divisor_r <= cfg_wdata[DIV_W-1:0];
      end
      if (cfg_we && cfg_index == CFG_IDX_LIMIT) begin
        limit_r <= cfg_wdata[LIMIT_W-1:0];
      end
      phase_r     <= phase_nxt;
      bit_count_r <= bit_count_nxt;
      shift_r     <= shift_nxt;
      kind_r      <= kind_nxt;
      tare_r      <= tare_nxt;
      last_raw_r  <= last_raw_nxt;
      weight_r    <= weight_nxt;
      ovl_r       <= ovl_nxt;
      sclk_r      <= sclk_nxt;
      busy_r      <= busy_nxt;
      done_r      <= done_nxt;
      dcnt_r      <= dcnt_nxt;
    end
  end

  // Divider working registers
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign serial_clock = sclk_r;
  assign busy_res     = busy_r;
  assign done_res     = done_r;
  assign raw_count    = last_raw_r;
  assign weight       = weight_r;
  assign overload     = ovl_r;

endmodule

FILE: rtl/load_cell_serial_reader_tare.sv
// Top level of the load cell serial converter reader with tare.
// Each input transaction is one tick of the converter interface: func requests a tare or
// weigh read (ignored while a read is in progress) and data_pin is the converter's data
// line. Every tick returns exactly one result transaction with the serial clock level to
// drive, busy/done flags, the last raw count (sign bit inverted), the last weight and the
// overload flag. A tick is accepted and its result is then held until taken; the tick
// that completes a weigh read with a positive difference first computes the weight
// ((raw - tare) * 16) / scale_divisor_q4 in a 28-step restoring divider, one
// quotient bit per cycle. Configuration writes are registered and must be made
// while no tick is outstanding.
module load_cell_serial_reader_tare
  import lcsr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: [1:0] func, [2] data_pin, [7:3] zero
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: [0] serial_clock, [1] busy_res, [2] done_res, [26:3] raw_count,
  //            [50:27] weight, [51] overload, [55:52] zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  lcsr_cmd_t  cmd;
  lcsr_stat_t stat;

  logic             serial_clock;
  logic             busy_res;
  logic             done_res;
  logic [RAW_W-1:0] raw_count;
  logic [RAW_W-1:0] weight;
  logic             overload;

  lcsr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  lcsr_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .func         (in_tdata[1:0]),
    .data_pin     (in_tdata[2]),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .stat         (stat),
    .serial_clock (serial_clock),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .raw_count    (raw_count),
    .weight       (weight),
    .overload     (overload)
  );

  // Result packing
  assign out_tdata = {4'b0000, overload, weight, raw_count, done_res, busy_res, serial_clock};

endmodule

FILE: rtl/lcsr_checker.sv
// Port-level checker for the load cell reader, bound to the top level.
module lcsr_checker
  import lcsr_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // One tick in flight: never ready for input while a result is pending
  assert property (@(posedge clk) disable iff (!rst_n) !(in_tready && out_tvalid))
    else $error("input ready while result pending");

  // An accepted tick blocks input until its result is taken
  assert property (@(posedge clk) disable iff (!rst_n) (in_tvalid && in_tready) |=> !in_tready)
    else $error("second tick accepted before result delivered");

  // Stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  // Done and a serial clock pulse only occur inside a read
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[2] || out_tdata[0])) |-> out_tdata[1])
    else $error("done or serial clock without busy");

endmodule

bind load_cell_serial_reader_tare lcsr_checker u_lcsr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
